// File: hdl/smfp_pkg.sv
`timescale 1ns / 1ps

package smfp_pkg;

  // Field numbers captured by the schema
  localparam logic [4:0] FLD_ADDRESS   = 5'd1;
  localparam logic [4:0] FLD_TEAM      = 5'd3;
  localparam logic [4:0] FLD_ROBOT     = 5'd4;
  localparam logic [4:0] FLD_BATTERY   = 5'd5;
  localparam logic [4:0] FLD_CAPACITOR = 5'd6;
  localparam logic [4:0] FLD_VISION    = 5'd7;
  localparam logic [4:0] FLD_INFRARED  = 5'd8;
  localparam logic [4:0] FLD_IMU       = 5'd9;

  // Wire types
  localparam logic [2:0] WT_VARINT  = 3'd0;
  localparam logic [2:0] WT_FIXED64 = 3'd1;
  localparam logic [2:0] WT_LENGTH  = 3'd2;
  localparam logic [2:0] WT_FIXED32 = 3'd5;

  // Seen-mask bit positions
  localparam int unsigned SEEN_ADDRESS   = 0;
  localparam int unsigned SEEN_BATTERY   = 1;
  localparam int unsigned SEEN_CAPACITOR = 2;
  localparam int unsigned SEEN_VISION    = 3;
  localparam int unsigned SEEN_INFRARED  = 4;
  localparam int unsigned SEEN_IMU       = 5;

  // What a byte means if it turns up as a tag
  typedef enum logic [2:0] {
    ACT_VALUE,
    ACT_LEN,
    ACT_SKIP4,
    ACT_SKIP8,
    ACT_ERROR
  } tag_act_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [4:0] fid;
    logic       cont;
    tag_act_e   act;
  } byte_item_t;

  typedef struct packed {
    logic        valid_status;
    logic        malformed;
    logic [31:0] team_code;
    logic [30:0] robot_number;
    logic [31:0] battery_level;
    logic [31:0] address_last_octet;
    logic [31:0] capacitor_level;
    logic [31:0] infrared_reading;
    logic        vision_ok;
    logic        imu_fitted;
    logic [5:0]  present_mask;
  } result_t;

  function automatic tag_act_e classify(logic [4:0] fid, logic [2:0] wt);
    logic known;
    tag_act_e act;
    known = (fid == FLD_ADDRESS) || ((fid >= FLD_TEAM) && (fid <= FLD_IMU));
    if (known) begin
      act = (wt == WT_VARINT) ? ACT_VALUE : ACT_ERROR;
    end else begin
      unique case (wt)
        WT_VARINT:  act = ACT_VALUE;
        WT_LENGTH:  act = ACT_LEN;
        WT_FIXED32: act = ACT_SKIP4;
        WT_FIXED64: act = ACT_SKIP8;
        default:    act = ACT_ERROR;
      endcase
    end
    return act;
  endfunction

  // Zigzag decode, truncated to 32 bits
  function automatic logic [31:0] zz32(logic [63:0] v);
    return v[32:1] ^ {32{v[0]}};
  endfunction

endpackage

// File: hdl/smfp_front.sv
`timescale 1ns / 1ps

// Input side: two-entry byte queue, tag decode done on the way in
module smfp_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  input  logic [7:0]           data_byte_i,
  input  logic                 last_byte_i,
  output logic                 full,
  output logic                 head_valid_o,
  output smfp_pkg::byte_item_t head_o,
  input  logic                 take_i
);

  smfp_pkg::byte_item_t mem_q [2];
  smfp_pkg::byte_item_t item;
  logic [1:0] count_q, count_d;
  logic       wr_ptr_q, rd_ptr_q;
  logic       wr_en, rd_en;

  assign full         = (count_q == 2'd2);
  assign head_valid_o = (count_q != 2'd0);
  assign head_o       = mem_q[rd_ptr_q];
  assign wr_en        = push && !full;
  assign rd_en        = take_i && head_valid_o;

  always_comb begin
    item.data = data_byte_i;
    item.last = last_byte_i;
    item.fid  = data_byte_i[7:3];
    item.cont = data_byte_i[7];
    item.act  = smfp_pkg::classify(data_byte_i[7:3], data_byte_i[2:0]);
  end

  always_comb begin
    count_d = count_q;
    if (wr_en && !rd_en) begin
      count_d = count_q + 2'd1;
    end else if (rd_en && !wr_en) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (wr_en) wr_ptr_q <= ~wr_ptr_q;
      if (rd_en) rd_ptr_q <= ~rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_ptr_q] <= item;
  end

endmodule

// File: hdl/smfp_parser.sv
`timescale 1ns / 1ps

// Parse engine: one byte per cycle while a final byte has room to go, builds one result per datagram
module smfp_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 head_valid_i,
  input  smfp_pkg::byte_item_t head_i,
  output logic                 take_o,
  input  logic                 space_i,
  output logic                 res_valid_o,
  output smfp_pkg::result_t    res_o
);

  localparam logic [1:0] PH_TAG   = 2'd0;
  localparam logic [1:0] PH_VALUE = 2'd1;
  localparam logic [1:0] PH_LEN   = 2'd2;
  localparam logic [1:0] PH_SKIP  = 2'd3;

  logic [1:0]  phase_q, phase_d;
  logic [4:0]  fid_q, fid_d;
  logic [63:0] acc_q, acc_d;
  logic [6:0]  shift_q, shift_d;
  logic [63:0] skip_q, skip_d;
  logic [31:0] team_q, team_d;
  logic [31:0] robot_q, robot_d;
  logic [31:0] battery_q, battery_d;
  logic [31:0] address_q, address_d;
  logic [31:0] capacitor_q, capacitor_d;
  logic [31:0] infrared_q, infrared_d;
  logic [1:0]  flags_q, flags_d;
  logic [5:0]  seen_q, seen_d;
  logic        core_q, core_d;
  logic        err_q, err_d;
  logic [63:0] value;

  // A final byte needs room in the result queue
  assign take_o      = head_valid_i && (!head_i.last || space_i);
  assign res_valid_o = take_o && head_i.last;

  assign value = acc_q | ({57'd0, head_i.data[6:0]} << shift_q[5:0]);

  always_comb begin
    phase_d     = phase_q;
    fid_d       = fid_q;
    acc_d       = acc_q;
    shift_d     = shift_q;
    skip_d      = skip_q;
    team_d      = team_q;
    robot_d     = robot_q;
    battery_d   = battery_q;
    address_d   = address_q;
    capacitor_d = capacitor_q;
    infrared_d  = infrared_q;
    flags_d     = flags_q;
    seen_d      = seen_q;
    core_d      = core_q;
    err_d       = err_q;
    res_o       = '0;

    if (take_o && !err_q) begin
      unique case (phase_q)
        PH_TAG: begin
          fid_d   = head_i.fid;
          acc_d   = 64'd0;
          shift_d = 7'd0;
          unique case (head_i.act)
            smfp_pkg::ACT_VALUE: phase_d = PH_VALUE;
            smfp_pkg::ACT_LEN:   phase_d = PH_LEN;
            smfp_pkg::ACT_SKIP4: begin
              skip_d  = 64'd4;
              phase_d = PH_SKIP;
            end
            smfp_pkg::ACT_SKIP8: begin
              skip_d  = 64'd8;
              phase_d = PH_SKIP;
            end
            default: err_d = 1'b1;
          endcase
        end
        PH_VALUE, PH_LEN: begin
          acc_d = value;
          if (!head_i.cont) begin
            if (phase_q == PH_VALUE) begin
              phase_d = PH_TAG;
              unique case (fid_q)
                smfp_pkg::FLD_ADDRESS: begin
                  address_d = smfp_pkg::zz32(value);
                  seen_d[smfp_pkg::SEEN_ADDRESS] = 1'b1;
                end
                smfp_pkg::FLD_TEAM: begin
                  team_d = value[31:0];
                  core_d = 1'b1;
                end
                smfp_pkg::FLD_ROBOT: begin
                  robot_d = value[31:0];
                  core_d  = 1'b1;
                end
                smfp_pkg::FLD_BATTERY: begin
                  battery_d = smfp_pkg::zz32(value);
                  core_d    = 1'b1;
                  seen_d[smfp_pkg::SEEN_BATTERY] = 1'b1;
                end
                smfp_pkg::FLD_CAPACITOR: begin
                  capacitor_d = smfp_pkg::zz32(value);
                  seen_d[smfp_pkg::SEEN_CAPACITOR] = 1'b1;
                end
                smfp_pkg::FLD_VISION: begin
                  flags_d[0] = (value != 64'd0);
                  seen_d[smfp_pkg::SEEN_VISION] = 1'b1;
                end
                smfp_pkg::FLD_INFRARED: begin
                  infrared_d = smfp_pkg::zz32(value);
                  seen_d[smfp_pkg::SEEN_INFRARED] = 1'b1;
                end
                smfp_pkg::FLD_IMU: begin
                  flags_d[1] = (value != 64'd0);
                  seen_d[smfp_pkg::SEEN_IMU] = 1'b1;
                end
                default: ;
              endcase
            end else begin
              skip_d  = value;
              phase_d = (value == 64'd0) ? PH_TAG : PH_SKIP;
            end
          end else begin
            shift_d = shift_q + 7'd7;
            if (shift_d > 7'd63) err_d = 1'b1;
          end
        end
        PH_SKIP: begin
          skip_d = skip_q - 64'd1;
          if (skip_q == 64'd1) phase_d = PH_TAG;
        end
        default: ;
      endcase
    end

    if (res_valid_o) begin
      // Datagram ended inside a varint
      if (phase_d == PH_VALUE || phase_d == PH_LEN) err_d = 1'b1;

      res_o.valid_status       = !err_d && core_d && (team_d != 32'd0);
      res_o.malformed          = err_d;
      res_o.team_code          = team_d;
      res_o.robot_number       = robot_d[31] ? 31'd0 : robot_d[30:0];
      res_o.battery_level      = battery_d;
      res_o.address_last_octet = address_d;
      res_o.capacitor_level    = capacitor_d;
      res_o.infrared_reading   = infrared_d;
      res_o.vision_ok          = flags_d[0];
      res_o.imu_fitted         = flags_d[1];
      res_o.present_mask       = seen_d;

      phase_d     = PH_TAG;
      fid_d       = 5'd0;
      acc_d       = 64'd0;
      shift_d     = 7'd0;
      skip_d      = 64'd0;
      team_d      = 32'd0;
      robot_d     = '1;
      battery_d   = 32'd0;
      address_d   = 32'd0;
      capacitor_d = 32'd0;
      infrared_d  = 32'd0;
      flags_d     = 2'd0;
      seen_d      = 6'd0;
      core_d      = 1'b0;
      err_d       = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_TAG;
      fid_q       <= 5'd0;
      acc_q       <= 64'd0;
      shift_q     <= 7'd0;
      skip_q      <= 64'd0;
      team_q      <= 32'd0;
      robot_q     <= '1;
      battery_q   <= 32'd0;
      address_q   <= 32'd0;
      capacitor_q <= 32'd0;
      infrared_q  <= 32'd0;
      flags_q     <= 2'd0;
      seen_q      <= 6'd0;
      core_q      <= 1'b0;
      err_q       <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      fid_q       <= fid_d;
      acc_q       <= acc_d;
      shift_q     <= shift_d;
      skip_q      <= skip_d;
      team_q      <= team_d;
      robot_q     <= robot_d;
      battery_q   <= battery_d;
      address_q   <= address_d;
      capacitor_q <= capacitor_d;
      infrared_q  <= infrared_d;
      flags_q     <= flags_d;
      seen_q      <= seen_d;
      core_q      <= core_d;
      err_q       <= err_d;
    end
  end

endmodule

// File: hdl/smfp_out_queue.sv
`timescale 1ns / 1ps

// Two-entry result queue
module smfp_out_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_i,
  input  smfp_pkg::result_t wr_data_i,
  output logic              space_o,
  output logic              empty,
  input  logic              pop,
  output smfp_pkg::result_t head_o
);

  smfp_pkg::result_t mem_q [2];
  logic [1:0] count_q, count_d;
  logic       wr_ptr_q, rd_ptr_q;
  logic       rd_en;

  assign empty   = (count_q == 2'd0);
  assign rd_en   = pop && !empty;
  assign space_o = (count_q != 2'd2) || rd_en;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (wr_i && !rd_en) begin
      count_d = count_q + 2'd1;
    end else if (rd_en && !wr_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (wr_i)  wr_ptr_q <= ~wr_ptr_q;
      if (rd_en) rd_ptr_q <= ~rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wr_ptr_q] <= wr_data_i;
  end

endmodule

// File: hdl/status_message_field_parser.sv
`timescale 1ns / 1ps

// Status message field parser: decodes one protobuf-style datagram per result.
// Input channel: a queue write port. A byte (data_byte_i, last_byte_i marks
//   the final byte) is taken on a rising edge with push high and full low.
// Result channel: a queue read port. While empty is low the oldest result
//   sits on the result ports; it is taken on an edge with pop high.
// Throughput: one byte per cycle while final bytes find room in the result
//   queue, set by the parse engine (tag decode, varint shift-in, 64-bit skip
//   countdown). Result path: a final byte is written into the input queue,
//   then parsed and written into the result queue, whose head is shown on
//   the result ports until popped.
// Reset: both queues empty, parse state back to expecting a tag.
// Receiver stall: up to two results are held; after that the final byte of
//   the next datagram waits at the head of the input queue, which then
//   fills and raises full. Ordinary bytes keep flowing until a final byte
//   has nowhere to go.
module status_message_field_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  input  logic [7:0]         data_byte_i,
  input  logic               last_byte_i,
  output logic               full,
  output logic               empty,
  input  logic               pop,
  output logic               valid_status_o,
  output logic               malformed_o,
  output logic signed [31:0] team_code_o,
  output logic [30:0]        robot_number_o,
  output logic signed [31:0] battery_level_o,
  output logic signed [31:0] address_last_octet_o,
  output logic signed [31:0] capacitor_level_o,
  output logic signed [31:0] infrared_reading_o,
  output logic               vision_ok_o,
  output logic               imu_fitted_o,
  output logic [5:0]         present_mask_o
);

  smfp_pkg::byte_item_t head;
  smfp_pkg::result_t    res;
  smfp_pkg::result_t    out;
  logic head_valid;
  logic take;
  logic res_valid;
  logic space;

  // Front end: queue each byte together with its tag decode
  smfp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .full         (full),
    .head_valid_o (head_valid),
    .head_o       (head),
    .take_i       (take)
  );

  // Back end: parse state and captured fields
  smfp_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .take_o       (take),
    .space_i      (space),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // Finished results wait here for the receiver
  smfp_out_queue u_out_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (res_valid),
    .wr_data_i (res),
    .space_o   (space),
    .empty     (empty),
    .pop       (pop),
    .head_o    (out)
  );

  assign valid_status_o       = out.valid_status;
  assign malformed_o          = out.malformed;
  assign team_code_o          = $signed(out.team_code);
  assign robot_number_o       = out.robot_number;
  assign battery_level_o      = $signed(out.battery_level);
  assign address_last_octet_o = $signed(out.address_last_octet);
  assign capacitor_level_o    = $signed(out.capacitor_level);
  assign infrared_reading_o   = $signed(out.infrared_reading);
  assign vision_ok_o          = out.vision_ok;
  assign imu_fitted_o         = out.imu_fitted;
  assign present_mask_o       = out.present_mask;

endmodule

// File: tb/tb_status_message_field_parser.sv
`timescale 1ns / 1ps

// Self-checking bench for the status message field parser.
// Bytes go in through the queue write port, one parsed status per datagram
// comes out of the queue read port. A scoreboard predicts each status from
// the bytes as they are accepted and checks every popped result in order.
module tb_status_message_field_parser;
  import smfp_pkg::*;

  // Stimulus sizing and timing
  localparam int unsigned RANDOM_BYTES   = 950;
  localparam int unsigned QUIET_TAIL     = 150;   // no idling over the final stretch
  localparam int unsigned WATCHDOG_LIMIT = 4000;  // cycles with no transaction at all
  localparam int unsigned LONG_HOLD_AT   = 600;   // receiver cycle at which the long hold starts
  localparam int unsigned LONG_HOLD_LEN  = 400;
  localparam int unsigned DRAIN_CYCLES   = 10;    // margin after the last expected status, to catch a stray extra pop

  // Wire types the schema never accepts
  localparam logic [2:0] WT_START_GROUP = 3'd3;
  localparam logic [2:0] WT_END_GROUP   = 3'd4;
  localparam logic [2:0] WT_RSVD6       = 3'd6;
  localparam logic [2:0] WT_RSVD7       = 3'd7;

  // Field numbers the schema does not capture
  localparam logic [4:0] FLD_SPARE = 5'd2;
  localparam logic [4:0] FLD_TOP   = 5'd31;

  localparam logic [4:0] KNOWN_IDS [8] = '{FLD_ADDRESS, FLD_TEAM, FLD_ROBOT, FLD_BATTERY,
                                           FLD_CAPACITOR, FLD_VISION, FLD_INFRARED, FLD_IMU};
  localparam logic [2:0] BAD_WTS [4] = '{WT_START_GROUP, WT_END_GROUP, WT_RSVD6, WT_RSVD7};

  typedef enum logic [1:0] {
    PH_TAG,
    PH_VALUE,
    PH_LEN,
    PH_SKIP
  } parse_ph_e;

  // Predicts one status per datagram and checks popped results in order.
  class datagram_scoreboard;
    parse_ph_e   ph;
    logic [4:0]  fid;
    logic [2:0]  wt;
    logic [63:0] acc;
    int unsigned shamt;
    logic [63:0] skip_left;
    logic [31:0] team, robot, battery, address, capacitor, infrared;
    logic [1:0]  flags;      // bit 0 vision, bit 1 imu
    logic [5:0]  seen;
    logic        core_seen;
    logic        fault;
    result_t     expected_status_q[$];
    int unsigned mismatch_cnt;

    function new();
      mismatch_cnt = 0;
      clear_datagram();
    endfunction

    function void clear_datagram();
      ph        = PH_TAG;
      fid       = '0;
      wt        = '0;
      acc       = '0;
      shamt     = 0;
      skip_left = '0;
      team      = '0;
      robot     = '1;  // all ones marks robot number absent
      battery   = '0;
      address   = '0;
      capacitor = '0;
      infrared  = '0;
      flags     = '0;
      seen      = '0;
      core_seen = 1'b0;
      fault     = 1'b0;
    endfunction

    function logic [31:0] unzigzag(logic [63:0] v);
      logic [63:0] r;
      r = (v >> 1) ^ (64'd0 - {63'd0, v[0]});
      return r[31:0];
    endfunction

    function void capture(logic [63:0] v);
      case (fid)
        FLD_ADDRESS: begin
          address = unzigzag(v);
          seen[SEEN_ADDRESS] = 1'b1;
        end
        FLD_TEAM: begin
          team = v[31:0];
          core_seen = 1'b1;
        end
        FLD_ROBOT: begin
          robot = v[31:0];
          core_seen = 1'b1;
        end
        FLD_BATTERY: begin
          battery = unzigzag(v);
          core_seen = 1'b1;
          seen[SEEN_BATTERY] = 1'b1;
        end
        FLD_CAPACITOR: begin
          capacitor = unzigzag(v);
          seen[SEEN_CAPACITOR] = 1'b1;
        end
        FLD_VISION: begin
          flags[0] = (v != 0);
          seen[SEEN_VISION] = 1'b1;
        end
        FLD_INFRARED: begin
          infrared = unzigzag(v);
          seen[SEEN_INFRARED] = 1'b1;
        end
        FLD_IMU: begin
          flags[1] = (v != 0);
          seen[SEEN_IMU] = 1'b1;
        end
        default: ;
      endcase
    endfunction

    function void begin_skip(logic [63:0] n);
      skip_left = n;
      ph = (n == 0) ? PH_TAG : PH_SKIP;
    endfunction

    function void decode_tag(logic [7:0] b);
      logic known;
      fid   = b[7:3];
      wt    = b[2:0];
      acc   = '0;
      shamt = 0;
      known = (fid == FLD_ADDRESS) || ((fid >= FLD_TEAM) && (fid <= FLD_IMU));
      if (known) begin
        if (wt != WT_VARINT) fault = 1'b1;
        else ph = PH_VALUE;
      end else begin
        case (wt)
          WT_VARINT:  ph = PH_VALUE;
          WT_LENGTH:  ph = PH_LEN;
          WT_FIXED32: begin_skip(64'd4);
          WT_FIXED64: begin_skip(64'd8);
          default:    fault = 1'b1;
        endcase
      end
    endfunction

    // Base-128 group, least significant first; the tenth group keeps only bit 0
    function void shift_in(logic [7:0] b);
      acc = acc | ({57'd0, b[6:0]} << (shamt & 63));
      if (!b[7]) begin
        if (ph == PH_VALUE) begin
          capture(acc);
          ph = PH_TAG;
        end else begin
          begin_skip(acc);
        end
      end else begin
        shamt += 7;
        if (shamt > 63) fault = 1'b1;
      end
    endfunction

    function void note_byte(logic [7:0] b, logic is_last);
      result_t r;
      if (!fault) begin
        case (ph)
          PH_TAG:           decode_tag(b);
          PH_VALUE, PH_LEN: shift_in(b);
          default: begin
            skip_left -= 1;
            if (skip_left == 0) ph = PH_TAG;
          end
        endcase
      end
      if (is_last) begin
        // datagram ends inside a varint or straight after a tag needing one
        if (!fault && (ph == PH_VALUE || ph == PH_LEN)) fault = 1'b1;
        r.valid_status       = !fault && core_seen && (team != 0);
        r.malformed          = fault;
        r.team_code          = team;
        r.robot_number       = robot[31] ? 31'd0 : robot[30:0];
        r.battery_level      = battery;
        r.address_last_octet = address;
        r.capacitor_level    = capacitor;
        r.infrared_reading   = infrared;
        r.vision_ok          = flags[0];
        r.imu_fitted         = flags[1];
        r.present_mask       = seen;
        expected_status_q.push_back(r);
        clear_datagram();
      end
    endfunction

    function void report(string msg);
      mismatch_cnt++;
      if (mismatch_cnt <= 10) $display("%0t: %s", $time, msg);
    endfunction

    function void compare_field(string name, logic [31:0] e, logic [31:0] a);
      if (a !== e) report($sformatf("%s: expected 0x%08h, got 0x%08h", name, e, a));
    endfunction

    function void check_status(result_t got);
      result_t e;
      if (expected_status_q.size() == 0) begin
        report("status popped with none outstanding");
        return;
      end
      e = expected_status_q.pop_front();
      compare_field("valid_status", {31'd0, e.valid_status}, {31'd0, got.valid_status});
      compare_field("malformed", {31'd0, e.malformed}, {31'd0, got.malformed});
      compare_field("team_code", e.team_code, got.team_code);
      compare_field("robot_number", {1'b0, e.robot_number}, {1'b0, got.robot_number});
      compare_field("battery_level", e.battery_level, got.battery_level);
      compare_field("address_last_octet", e.address_last_octet, got.address_last_octet);
      compare_field("capacitor_level", e.capacitor_level, got.capacitor_level);
      compare_field("infrared_reading", e.infrared_reading, got.infrared_reading);
      compare_field("vision_ok", {31'd0, e.vision_ok}, {31'd0, got.vision_ok});
      compare_field("imu_fitted", {31'd0, e.imu_fitted}, {31'd0, got.imu_fitted});
      compare_field("present_mask", {26'd0, e.present_mask}, {26'd0, got.present_mask});
    endfunction

    function int unsigned outstanding();
      return expected_status_q.size();
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               push;
  logic [7:0]         data_byte_i;
  logic               last_byte_i;
  logic               full;
  logic               empty;
  logic               pop;
  logic               valid_status_o;
  logic               malformed_o;
  logic signed [31:0] team_code_o;
  logic [30:0]        robot_number_o;
  logic signed [31:0] battery_level_o;
  logic signed [31:0] address_last_octet_o;
  logic signed [31:0] capacitor_level_o;
  logic signed [31:0] infrared_reading_o;
  logic               vision_ok_o;
  logic               imu_fitted_o;
  logic [5:0]         present_mask_o;

  datagram_scoreboard sb;
  logic [7:0]         dgram[$];     // datagram being built, sent front to back
  logic               tx_gappy;     // sender idles in bursts during this datagram
  logic               quiet_phase;  // final stretch: neither side idles
  int unsigned        stall_cycles;

  status_message_field_parser u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .push                (push),
    .data_byte_i         (data_byte_i),
    .last_byte_i         (last_byte_i),
    .full                (full),
    .empty               (empty),
    .pop                 (pop),
    .valid_status_o      (valid_status_o),
    .malformed_o         (malformed_o),
    .team_code_o         (team_code_o),
    .robot_number_o      (robot_number_o),
    .battery_level_o     (battery_level_o),
    .address_last_octet_o(address_last_octet_o),
    .capacitor_level_o   (capacitor_level_o),
    .infrared_reading_o  (infrared_reading_o),
    .vision_ok_o         (vision_ok_o),
    .imu_fitted_o        (imu_fitted_o),
    .present_mask_o      (present_mask_o)
  );

  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Random varint: mostly short, sometimes up to the full ten groups.
  // Groups are biased towards all-zero and all-ones to hit the extremes.
  function automatic void put_varint();
    int unsigned nbytes;
    logic [7:0]  b;
    nbytes = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 10) : $urandom_range(1, 5);
    for (int unsigned i = 0; i < nbytes; i++) begin
      case ($urandom_range(0, 7))
        0:       b = 8'h00;
        1:       b = 8'h7F;
        default: b = {1'b0, 7'($urandom)};
      endcase
      if (i < nbytes - 1) b[7] = 1'b1;
      dgram.push_back(b);
    end
  endfunction

  // One byte transaction; an idle burst may come first. The accepting edge is
  // sampled before the block updates, so full is its pre-edge value.
  task automatic send_byte(logic [7:0] b, logic is_last);
    if (tx_gappy && !quiet_phase && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    push        <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= is_last;
    do @(posedge clk_i); while (full);
    sb.note_byte(b, is_last);
  endtask

  task automatic send_datagram();
    for (int unsigned i = 0; i < dgram.size(); i++) send_byte(dgram[i], i == dgram.size() - 1);
  endtask

  // Sender: reset, directed datagrams, then random datagrams, then drain and verdict
  initial begin
    int unsigned sent;
    int unsigned kind;
    int unsigned sel;
    int unsigned len;
    int unsigned cut;
    logic [4:0]  fid;

    rst_ni      = 1'b0;
    push        = 1'b0;
    data_byte_i = '0;
    last_byte_i = 1'b0;
    tx_gappy    = 1'b0;
    quiet_phase = 1'b0;
    sb = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Truncated: datagram ends straight after a tag that needs a varint
    dgram = '{{FLD_TEAM, WT_VARINT}};
    send_datagram();
    // Known field with the wrong wire type; the trailing byte is ignored
    dgram = '{{FLD_TEAM, WT_FIXED64}, 8'hAA};
    send_datagram();
    // Unknown fields with wire types that cannot be skipped
    dgram = '{{FLD_SPARE, WT_START_GROUP}};
    send_datagram();
    dgram = '{{FLD_TOP, WT_RSVD7}};
    send_datagram();
    // Ten-group team value (only bit 0 of the tenth group counts),
    // then a fixed32 skip that runs past the end of the datagram
    dgram = '{{FLD_TEAM, WT_VARINT}, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
              8'hFF, 8'h7F, {FLD_SPARE, WT_FIXED32}, 8'h01};
    send_datagram();
    // Zero-length skip, then every captured field once, team left at zero
    dgram = '{{FLD_SPARE, WT_LENGTH}, 8'h00, {FLD_ADDRESS, WT_VARINT}, 8'h01,
              {FLD_BATTERY, WT_VARINT}, 8'h00, {FLD_CAPACITOR, WT_VARINT}, 8'h02,
              {FLD_VISION, WT_VARINT}, 8'h00, {FLD_INFRARED, WT_VARINT}, 8'h03,
              {FLD_IMU, WT_VARINT}, 8'h01, {FLD_ROBOT, WT_VARINT}, 8'h7F,
              {FLD_TEAM, WT_VARINT}, 8'h00};
    send_datagram();

    // Random part: mostly well-formed datagrams with random content, the rest
    // truncated, corrupted or plain noise.
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      dgram.delete();
      kind = $urandom_range(0, 9);
      if (kind == 9) begin
        repeat ($urandom_range(1, 12)) dgram.push_back(8'($urandom));
      end else begin
        repeat ($urandom_range(1, 5)) begin
          sel = $urandom_range(0, 9);
          if (sel <= 5) begin
            dgram.push_back({KNOWN_IDS[$urandom_range(0, 7)], WT_VARINT});
            put_varint();
          end else begin
            // unknown field number: 0, 2 or 10 to 31
            len = $urandom_range(0, 23);
            fid = (len == 0) ? 5'd0 : (len == 1) ? FLD_SPARE : 5'(len + 8);
            case (sel)
              6: begin
                dgram.push_back({fid, WT_VARINT});
                put_varint();
              end
              7: begin
                dgram.push_back({fid, WT_LENGTH});
                if ($urandom_range(0, 7) == 0) begin
                  put_varint();  // usually huge: skips the rest of the datagram
                end else begin
                  len = $urandom_range(0, 6);
                  dgram.push_back(8'(len));
                  repeat (len) dgram.push_back(8'($urandom));
                end
              end
              8: begin
                dgram.push_back({fid, WT_FIXED32});
                repeat (4) dgram.push_back(8'($urandom));
              end
              default: begin
                dgram.push_back({fid, WT_FIXED64});
                repeat (8) dgram.push_back(8'($urandom));
              end
            endcase
          end
        end
        if (kind == 7 && dgram.size() > 1) begin
          cut = $urandom_range(1, dgram.size() - 1);
          while (dgram.size() > cut) void'(dgram.pop_back());
        end else if (kind == 8) begin
          case ($urandom_range(0, 2))
            0: dgram.push_back({5'($urandom), BAD_WTS[$urandom_range(0, 3)]});
            1: dgram.push_back({KNOWN_IDS[$urandom_range(0, 7)], 3'($urandom_range(1, 7))});
            default: begin
              // overlong varint: continuation set on all ten groups
              dgram.push_back({KNOWN_IDS[$urandom_range(0, 7)], WT_VARINT});
              repeat (10) dgram.push_back({1'b1, 7'($urandom)});
            end
          endcase
          repeat ($urandom_range(0, 4)) dgram.push_back(8'($urandom));
        end
      end
      if (sent + dgram.size() + QUIET_TAIL >= RANDOM_BYTES) quiet_phase <= 1'b1;
      tx_gappy = ($urandom_range(0, 2) != 0);
      send_datagram();
      sent += dgram.size();
    end
    push <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatch_cnt == 0 && sb.outstanding() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Receiver: checks each popped status, stalls in short random bursts and
  // once for a long stretch so that both queues fill and full rises.
  initial begin
    result_t     got;
    int unsigned hold_left;
    int unsigned rx_cycles;
    logic        rx_gappy;

    pop       = 1'b0;
    hold_left = 0;
    rx_cycles = 0;
    rx_gappy  = 1'b1;
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        got.valid_status       = valid_status_o;
        got.malformed          = malformed_o;
        got.team_code          = team_code_o;
        got.robot_number       = robot_number_o;
        got.battery_level      = battery_level_o;
        got.address_last_octet = address_last_octet_o;
        got.capacitor_level    = capacitor_level_o;
        got.infrared_reading   = infrared_reading_o;
        got.vision_ok          = vision_ok_o;
        got.imu_fitted         = imu_fitted_o;
        got.present_mask       = present_mask_o;
        sb.check_status(got);
      end
      rx_cycles++;
      if (rx_cycles % 64 == 0) rx_gappy = 1'($urandom_range(0, 1));
      if (rx_cycles == LONG_HOLD_AT) hold_left = LONG_HOLD_LEN;
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (rx_gappy && !quiet_phase && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(0, 7);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run once nothing has moved on either side for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

endmodule
